// File: design/servo_trimmed_mean_p_drive_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the servo drive block
// Each macro checks a property on the clk / rst_n of the module that uses it.
// ----------------------------------------------------------------------------
`ifndef SERVO_TRIMMED_MEAN_P_DRIVE_MACROS_SVH
`define SERVO_TRIMMED_MEAN_P_DRIVE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define STMPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define STMPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/stmpd_pkg.sv
// ----------------------------------------------------------------------------
// stmpd_pkg
// Widths, constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package stmpd_pkg;

  localparam int unsigned MAX_SAMPLES = 16;
  localparam int unsigned MIN_SAMPLES = 3;
  localparam int unsigned FULL_SCALE  = 1023;
  localparam int unsigned DUTY_TOP    = 255;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned SPR_W    = 5;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned LEN_W  = (CNT_W > SPR_W) ? CNT_W : SPR_W;
  localparam int unsigned SUM_W  = $clog2(MAX_SAMPLES * ((2 ** SAMPLE_W) - 1) + 1);
  localparam int unsigned FS_W   = $clog2(FULL_SCALE + 1);
  localparam int unsigned MAG_W  = FS_W;
  localparam int unsigned DBL_W  = SAMPLE_W + 1;
  localparam int unsigned CMP_W  = (DBL_W > FS_W) ? DBL_W : FS_W;
  localparam int unsigned DVD_W  = SUM_W;
  localparam int unsigned DVSR_W = CNT_W;
  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  // Duty scaling mag * DUTY_TOP / FULL_SCALE as a multiply by a rounded-up
  // reciprocal and a shift; exact for every magnitude up to full scale
  localparam int unsigned DUTY_SHIFT    = 28;
  localparam logic [63:0] DUTY_RECIP_64 =
    ((64'(DUTY_TOP) << DUTY_SHIFT) + 64'(FULL_SCALE) - 64'(1)) / 64'(FULL_SCALE);
  localparam int unsigned RECIP_W       = $clog2(DUTY_RECIP_64 + 64'(1));
  localparam logic [RECIP_W-1:0] DUTY_RECIP = RECIP_W'(DUTY_RECIP_64);
  localparam int unsigned PROD_W        = MAG_W + RECIP_W;

  localparam logic [SPR_W-1:0]  SPR_RESET      = SPR_W'(10);
  localparam logic [DUTY_W-1:0] DEADBAND_RESET = DUTY_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPR      = 1'b0,
    CFG_DEADBAND = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_STANDBY  = 2'd0,
    DIR_FORWARD  = 2'd1,
    DIR_BACKWARD = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    S_ACC,
    S_POS_START,
    S_POS_RUN,
    S_DUTY_START,
    S_PUBLISH
  } state_t;

  typedef struct packed {
    logic accum;
    logic pos_start;
    logic take_pos;
    logic duty_start;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

// File: design/stmpd_div.sv
// ----------------------------------------------------------------------------
// stmpd_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stmpd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [stmpd_pkg::DVD_W-1:0]   dividend,
  input  logic [stmpd_pkg::DVSR_W-1:0]  divisor,
  output logic                          busy,
  output logic [stmpd_pkg::DVD_W-1:0]   quotient
);

  logic [stmpd_pkg::DVD_W-1:0]  quo_r,  quo_nxt;
  logic [stmpd_pkg::DVSR_W-1:0] rem_r,  rem_nxt;
  logic [stmpd_pkg::DVSR_W-1:0] dvsr_r, dvsr_nxt;
  logic [stmpd_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [stmpd_pkg::DVSR_W:0]   trial;

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    step_nxt = step_r;
    trial    = {rem_r, quo_r[stmpd_pkg::DVD_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvsr_nxt = divisor;
      step_nxt = stmpd_pkg::STEP_W'(stmpd_pkg::DVD_W);
    end else if (busy) begin
      if (trial >= {1'b0, dvsr_r}) begin
        rem_nxt = stmpd_pkg::DVSR_W'(trial - {1'b0, dvsr_r});
        quo_nxt = {quo_r[stmpd_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[stmpd_pkg::DVSR_W-1:0];
        quo_nxt = {quo_r[stmpd_pkg::DVD_W-2:0], 1'b0};
      end
      step_nxt = step_r - stmpd_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign busy     = (step_r != '0);
  assign quotient = quo_r;

endmodule

// File: design/stmpd_dp.sv
// ----------------------------------------------------------------------------
// stmpd_dp
// Datapath: registers, window accumulation, error and duty, output register.
// ----------------------------------------------------------------------------
`include "servo_trimmed_mean_p_drive_macros.svh"

module stmpd_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  stmpd_pkg::ctrl_cmd_t            cmd_i,
  output stmpd_pkg::dp_stat_t             stat_o,
  input  logic [stmpd_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [stmpd_pkg::SAMPLE_W-1:0]  in_target,
  input  logic                            cfg_we,
  input  logic [stmpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stmpd_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [stmpd_pkg::SAMPLE_W-1:0]  out_position,
  output logic [1:0]                      out_direction,
  output logic [stmpd_pkg::DUTY_W-1:0]    out_duty,
  output logic                            out_at_target
);

  logic [stmpd_pkg::SPR_W-1:0]    spr_r, spr_nxt;
  logic [stmpd_pkg::DUTY_W-1:0]   deadband_r, deadband_nxt;
  logic [stmpd_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [stmpd_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [stmpd_pkg::SAMPLE_W-1:0] min_r, min_nxt;
  logic [stmpd_pkg::SAMPLE_W-1:0] max_r, max_nxt;
  logic [stmpd_pkg::SAMPLE_W-1:0] target_r, target_nxt;
  logic [stmpd_pkg::SAMPLE_W-1:0] pos_r, pos_nxt;
  stmpd_pkg::dir_t                dir_r, dir_nxt;
  logic                           at_r, at_nxt;
  logic [stmpd_pkg::MAG_W-1:0]    mag_r, mag_nxt;
  logic [stmpd_pkg::DUTY_W-1:0]   duty_r, duty_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [stmpd_pkg::SAMPLE_W-1:0] out_pos_r, out_pos_nxt;
  stmpd_pkg::dir_t                out_dir_r, out_dir_nxt;
  logic [stmpd_pkg::DUTY_W-1:0]   out_duty_r, out_duty_nxt;
  logic                           out_at_r, out_at_nxt;

  logic [stmpd_pkg::LEN_W-1:0]    win_len;
  logic [stmpd_pkg::DVD_W-1:0]    div_dvd;
  logic [stmpd_pkg::DVSR_W-1:0]   div_dvsr;
  logic                           div_busy;
  logic [stmpd_pkg::DVD_W-1:0]    div_quo;
  logic [stmpd_pkg::SAMPLE_W-1:0] q_pos;
  logic [stmpd_pkg::SAMPLE_W-1:0] diff;
  logic [stmpd_pkg::DBL_W-1:0]    dbl;
  logic [stmpd_pkg::PROD_W-1:0]   duty_prod;
  logic [stmpd_pkg::DUTY_W-1:0]   duty_raw;

  // Clamp the programmed window length into its legal range
  always_comb begin
    win_len = stmpd_pkg::LEN_W'(spr_r);
    if (win_len < stmpd_pkg::LEN_W'(stmpd_pkg::MIN_SAMPLES)) begin
      win_len = stmpd_pkg::LEN_W'(stmpd_pkg::MIN_SAMPLES);
    end else if (win_len > stmpd_pkg::LEN_W'(stmpd_pkg::MAX_SAMPLES)) begin
      win_len = stmpd_pkg::LEN_W'(stmpd_pkg::MAX_SAMPLES);
    end
  end

  // Feed the divider with the trimmed sum and the trimmed count
  always_comb begin
    div_dvd  = stmpd_pkg::DVD_W'(sum_r - stmpd_pkg::SUM_W'(min_r)
                                       - stmpd_pkg::SUM_W'(max_r));
    div_dvsr = stmpd_pkg::DVSR_W'(count_r - stmpd_pkg::CNT_W'(2));
  end

  stmpd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd_i.pos_start),
    .dividend (div_dvd),
    .divisor  (div_dvsr),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Error against target: absolute difference, doubled
  always_comb begin
    q_pos = div_quo[stmpd_pkg::SAMPLE_W-1:0];
    if (q_pos > target_r) begin
      diff = q_pos - target_r;
    end else begin
      diff = target_r - q_pos;
    end
    dbl = {diff, 1'b0};
  end

  // Scale the magnitude to a duty by reciprocal multiplication, then deadband
  always_comb begin
    duty_prod = stmpd_pkg::PROD_W'(mag_r) * stmpd_pkg::PROD_W'(stmpd_pkg::DUTY_RECIP);
    duty_raw  = stmpd_pkg::DUTY_W'(duty_prod >> stmpd_pkg::DUTY_SHIFT);
    if (duty_raw < deadband_r) begin
      duty_raw = '0;
    end
  end

  // Next state of registers, window and output stage
  always_comb begin
    spr_nxt       = spr_r;
    deadband_nxt  = deadband_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    target_nxt    = target_r;
    pos_nxt       = pos_r;
    dir_nxt       = dir_r;
    at_nxt        = at_r;
    mag_nxt       = mag_r;
    duty_nxt      = duty_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_dir_nxt   = out_dir_r;
    out_duty_nxt  = out_duty_r;
    out_at_nxt    = out_at_r;

    if (cfg_we) begin
      unique case (stmpd_pkg::cfg_idx_t'(cfg_index))
        stmpd_pkg::CFG_SPR:      spr_nxt = cfg_wdata[stmpd_pkg::SPR_W-1:0];
        stmpd_pkg::CFG_DEADBAND: deadband_nxt = cfg_wdata[stmpd_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end

    if (cmd_i.accum) begin
      sum_nxt    = sum_r + stmpd_pkg::SUM_W'(in_sample);
      count_nxt  = count_r + stmpd_pkg::CNT_W'(1);
      target_nxt = in_target;
      if (in_sample < min_r) begin
        min_nxt = in_sample;
      end
      if (in_sample > max_r) begin
        max_nxt = in_sample;
      end
    end

    if (cmd_i.take_pos) begin
      pos_nxt = q_pos;
      if (q_pos > target_r) begin
        dir_nxt = stmpd_pkg::DIR_FORWARD;
        at_nxt  = 1'b0;
      end else if (q_pos < target_r) begin
        dir_nxt = stmpd_pkg::DIR_BACKWARD;
        at_nxt  = 1'b0;
      end else begin
        dir_nxt = stmpd_pkg::DIR_STANDBY;
        at_nxt  = 1'b1;
      end
      if (stmpd_pkg::CMP_W'(dbl) > stmpd_pkg::CMP_W'(stmpd_pkg::FULL_SCALE)) begin
        mag_nxt = stmpd_pkg::MAG_W'(stmpd_pkg::FULL_SCALE);
      end else begin
        mag_nxt = stmpd_pkg::MAG_W'(dbl);
      end
    end

    // Hold the scaled duty for the output stage
    if (cmd_i.duty_start) begin
      duty_nxt = duty_raw;
    end

    // Drop the result once taken; load a new one and restart the window
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd_i.publish) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = pos_r;
      out_dir_nxt   = dir_r;
      out_duty_nxt  = duty_r;
      out_at_nxt    = at_r;
      count_nxt     = '0;
      sum_nxt       = '0;
      min_nxt       = stmpd_pkg::SAMPLE_W'((2 ** stmpd_pkg::SAMPLE_W) - 1);
      max_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r       <= stmpd_pkg::SPR_RESET;
      deadband_r  <= stmpd_pkg::DEADBAND_RESET;
      count_r     <= '0;
      sum_r       <= '0;
      min_r       <= stmpd_pkg::SAMPLE_W'((2 ** stmpd_pkg::SAMPLE_W) - 1);
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      spr_r       <= spr_nxt;
      deadband_r  <= deadband_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
    target_r   <= target_nxt;
    pos_r      <= pos_nxt;
    dir_r      <= dir_nxt;
    at_r       <= at_nxt;
    mag_r      <= mag_nxt;
    duty_r     <= duty_nxt;
    out_pos_r  <= out_pos_nxt;
    out_dir_r  <= out_dir_nxt;
    out_duty_r <= out_duty_nxt;
    out_at_r   <= out_at_nxt;
  end

  // Status back to the controller
  assign stat_o.last     = (stmpd_pkg::LEN_W'(count_r) + stmpd_pkg::LEN_W'(1)) >= win_len;
  assign stat_o.div_busy = div_busy;
  assign stat_o.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_position  = out_pos_r;
  assign out_direction = out_dir_r;
  assign out_duty      = out_duty_r;
  assign out_at_target = out_at_r;

  `STMPD_ASSERT_NOW(a_accum_no_div, cmd_i.accum, !div_busy, "sample taken during division")
  `STMPD_ASSERT_NEXT(a_div_starts, cmd_i.pos_start, div_busy, "divider idle after start")
  `STMPD_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ready, out_valid_r && $stable(out_pos_r) && $stable(out_duty_r), "stalled result changed")
  `STMPD_ASSERT_NOW(a_count_bound, 1'b1, stmpd_pkg::LEN_W'(count_r) <= stmpd_pkg::LEN_W'(stmpd_pkg::MAX_SAMPLES), "window count overrun")

endmodule

// File: design/stmpd_ctrl.sv
// ----------------------------------------------------------------------------
// stmpd_ctrl
// Sequencer: accumulate a window, divide, scale the duty, publish the result.
// ----------------------------------------------------------------------------
module stmpd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  stmpd_pkg::dp_stat_t  stat_i,
  output stmpd_pkg::ctrl_cmd_t cmd_o
);

  stmpd_pkg::state_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stmpd_pkg::S_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through the window sequence and issue datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      stmpd_pkg::S_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.accum = 1'b1;
          if (stat_i.last) begin
            state_nxt = stmpd_pkg::S_POS_START;
          end
        end
      end
      stmpd_pkg::S_POS_START: begin
        cmd_o.pos_start = 1'b1;
        state_nxt       = stmpd_pkg::S_POS_RUN;
      end
      stmpd_pkg::S_POS_RUN: begin
        if (!stat_i.div_busy) begin
          cmd_o.take_pos = 1'b1;
          state_nxt      = stmpd_pkg::S_DUTY_START;
        end
      end
      stmpd_pkg::S_DUTY_START: begin
        cmd_o.duty_start = 1'b1;
        state_nxt        = stmpd_pkg::S_PUBLISH;
      end
      stmpd_pkg::S_PUBLISH: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_nxt     = stmpd_pkg::S_ACC;
        end
      end
      default: begin
        state_nxt = stmpd_pkg::S_ACC;
      end
    endcase
  end

endmodule

// File: design/servo_trimmed_mean_p_drive.sv
// ----------------------------------------------------------------------------
// servo_trimmed_mean_p_drive
// Proportional servo drive with trimmed-mean position feedback.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one ADC sample with its target per
// transaction. Samples of a window are taken one per cycle. When the window
// of samples_per_reading samples is complete, the block drops the minimum and
// maximum, divides the rest by N-2 and derives direction and duty.
// Output channel (out_valid/out_ready): one transaction per completed window.
// After the last sample of a window is taken, the block starts the serial
// divider, forms the mean (one quotient bit a cycle), takes position and
// error, scales the duty by reciprocal multiplication and loads the output
// register, which raises out_valid.
// in_ready is low from the last sample of a window until its result is
// loaded into the output register. While the receiver stalls, the result
// holds in that register and the next window is collected; its result waits
// until the register is free.
// Configuration writes (cfg_we) take effect at once and are meant for idle.
// Reset (rst_n low, synchronous) clears the window, drops any pending result
// and returns both registers to 10.
// ----------------------------------------------------------------------------
module servo_trimmed_mean_p_drive (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [stmpd_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [stmpd_pkg::SAMPLE_W-1:0]  in_target,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [stmpd_pkg::SAMPLE_W-1:0]  out_position,
  output logic [1:0]                      out_direction,
  output logic [stmpd_pkg::DUTY_W-1:0]    out_duty,
  output logic                            out_at_target,
  input  logic                            cfg_we,
  input  logic [stmpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stmpd_pkg::CFG_W-1:0]     cfg_wdata
);

  stmpd_pkg::ctrl_cmd_t cmd;
  stmpd_pkg::dp_stat_t  stat;

  stmpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  stmpd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_sample     (in_sample),
    .in_target     (in_target),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_position  (out_position),
    .out_direction (out_direction),
    .out_duty      (out_duty),
    .out_at_target (out_at_target)
  );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: servo drive with trimmed-mean feedback
// Streams ADC samples with targets into the block and checks each drive
// command (position, direction, duty, at-target flag) against a predictor
// that keeps its own window of sum, minimum, maximum and count. Both channels
// idle at random; register settings change between phases, while idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stmpd_pkg::*;

  localparam int unsigned IDLE_PCT      = 13;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 650;
  localparam int unsigned PHASE_ITEMS   = 60;
  localparam int unsigned REPORT_MAX    = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] target;
  } adc_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] position;
    dir_t                direction;
    logic [DUTY_W-1:0]   duty;
    logic                at_target;
  } drive_cmd_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic [SAMPLE_W-1:0]  in_sample = '0;
  logic [SAMPLE_W-1:0]  in_target = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic [SAMPLE_W-1:0]  out_position;
  logic [1:0]           out_direction;
  logic [DUTY_W-1:0]    out_duty;
  logic                 out_at_target;

  // pending samples and expected drive commands
  adc_item_t  adc_q[$];
  drive_cmd_t drive_q[$];

  // predictor copy of the registers and the sample window
  logic [SPR_W-1:0]    spr_shadow      = SPR_RESET;
  logic [DUTY_W-1:0]   deadband_shadow = DEADBAND_RESET;
  logic [CNT_W-1:0]    win_count       = '0;
  logic [SUM_W-1:0]    win_sum         = '0;
  logic [SAMPLE_W-1:0] win_min         = SAMPLE_W'(FULL_SCALE);
  logic [SAMPLE_W-1:0] win_max         = '0;

  int unsigned mismatches = 0;
  int unsigned quiet      = 0;
  bit          steady     = 1'b0;

  servo_trimmed_mean_p_drive dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_target     (in_target),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_position  (out_position),
    .out_direction (out_direction),
    .out_duty      (out_duty),
    .out_at_target (out_at_target),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #6 clk = ~clk;

  // window length after clamping the register to the legal range
  function automatic int unsigned window_len();
    int unsigned n;
    n = spr_shadow;
    if (n < MIN_SAMPLES) n = MIN_SAMPLES;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    return n;
  endfunction

  // fold one sample into the window; on completion queue the drive command
  task automatic predict_drive(input logic [SAMPLE_W-1:0] s, input logic [SAMPLE_W-1:0] tgt);
    int unsigned pos;
    int unsigned mag;
    int unsigned duty;
    drive_cmd_t  cmd;
    win_sum   = win_sum + s;
    if (s < win_min) win_min = s;
    if (s > win_max) win_max = s;
    win_count = win_count + 1'b1;
    if (win_count >= window_len()) begin
      pos = (int'(win_sum) - int'(win_min) - int'(win_max)) / (int'(win_count) - 2);
      cmd.position = SAMPLE_W'(pos);
      if (pos > tgt) begin
        cmd.direction = DIR_FORWARD;
        mag           = pos - tgt;
        cmd.at_target = 1'b0;
      end else if (pos < tgt) begin
        cmd.direction = DIR_BACKWARD;
        mag           = tgt - pos;
        cmd.at_target = 1'b0;
      end else begin
        cmd.direction = DIR_STANDBY;
        mag           = 0;
        cmd.at_target = 1'b1;
      end
      mag = 2 * mag;
      if (mag > FULL_SCALE) mag = FULL_SCALE;
      duty = mag * DUTY_TOP / FULL_SCALE;
      if (duty < deadband_shadow) duty = 0;
      cmd.duty = DUTY_W'(duty);
      drive_q.push_back(cmd);
      win_count = '0;
      win_sum   = '0;
      win_min   = SAMPLE_W'(FULL_SCALE);
      win_max   = '0;
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%0t ns: mismatch, %s", $time, msg);
  endtask

  // driver: present the next sample once the previous transaction has gone
  always @(posedge clk) begin
    adc_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_drive(in_sample, in_target);
      if (!in_valid || in_ready) begin
        if (adc_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = adc_q.pop_front();
          in_valid  <= 1'b1;
          in_sample <= nxt.sample;
          in_target <= nxt.target;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each drive command with the oldest expectation
  always @(posedge clk) begin
    drive_cmd_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          note_mismatch($sformatf("drive command with none expected, position %0d",
                                  out_position));
        end else begin
          want = drive_q.pop_front();
          if (out_position !== want.position)
            note_mismatch($sformatf("position expected %0d, got %0d",
                                    want.position, out_position));
          if (out_direction !== want.direction)
            note_mismatch($sformatf("direction expected %0d, got %0d",
                                    want.direction, out_direction));
          if (out_duty !== want.duty)
            note_mismatch($sformatf("duty expected %0d, got %0d", want.duty, out_duty));
          if (out_at_target !== want.at_target)
            note_mismatch($sformatf("at_target expected %0d, got %0d",
                                    want.at_target, out_at_target));
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_SPR) spr_shadow = val[SPR_W-1:0];
    else deadband_shadow = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_item(input int unsigned s, input int unsigned tgt);
    adc_item_t it;
    it.sample = SAMPLE_W'(s);
    it.target = SAMPLE_W'(tgt);
    adc_q.push_back(it);
  endtask

  // wait until every transaction is through, then let the datapath go quiet;
  // sample between edges so that the driver's updates have landed
  task automatic settle();
    while (adc_q.size() != 0 || in_valid || drive_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one window of n samples: fully random, clustered near the target, or rails
  task automatic push_window(input int unsigned n);
    int          base;
    int          v;
    int unsigned tgt;
    int unsigned mode;
    mode = $urandom_range(2);
    base = $urandom_range(FULL_SCALE);
    case (mode)
      0:       tgt = $urandom_range(FULL_SCALE);
      1:       tgt = $urandom_range((base > 3) ? base - 3 : 0,
                                    (base < FULL_SCALE - 3) ? base + 3 : FULL_SCALE);
      default: tgt = ($urandom_range(2) == 0) ? 0 :
                     ($urandom_range(1) == 0) ? FULL_SCALE : $urandom_range(FULL_SCALE);
    endcase
    for (int unsigned i = 0; i < n; i++) begin
      case (mode)
        0: v = $urandom_range(FULL_SCALE);
        1: begin
          v = base + int'($urandom_range(6)) - 3;
          if (v < 0) v = 0;
          if (v > int'(FULL_SCALE)) v = FULL_SCALE;
        end
        default: v = ($urandom_range(2) == 0) ? 0 :
                     ($urandom_range(1) == 0) ? FULL_SCALE : $urandom_range(FULL_SCALE);
      endcase
      push_item(v, tgt);
    end
  endtask

  // stimulus: directed windows, then random phases under changing settings
  initial begin
    logic [SPR_W-1:0] spr_corner [6];
    logic [DUTY_W-1:0] db_corner [3];
    int unsigned sent;
    int unsigned chunk;
    int unsigned n;
    logic [SPR_W-1:0] spr;
    logic [DUTY_W-1:0] db;
    spr_corner = '{5'd1, 5'd2, 5'd17, 5'd31, 5'd16, 5'd3};
    db_corner  = '{8'd255, 8'd0, 8'd1};
    sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // shortest window (zero register acts as three), no deadband
    write_reg(CFG_SPR, 8'd0);
    write_reg(CFG_DEADBAND, 8'd0);
    // all zero, on target
    push_item(0, 0); push_item(0, 0); push_item(0, 0);
    // full scale against zero: forward, duty saturates
    push_item(FULL_SCALE, 0); push_item(FULL_SCALE, 0); push_item(FULL_SCALE, 0);
    // zero against full scale: backward, duty saturates
    push_item(0, FULL_SCALE); push_item(0, FULL_SCALE); push_item(0, FULL_SCALE);
    // extremes trimmed away, middle sample lands on the target
    push_item(5, 0); push_item(500, 0); push_item(FULL_SCALE, 500);
    // one count of error truncates to zero duty
    push_item(600, 0); push_item(600, 0); push_item(600, 599);
    settle();

    // shorten the window mid-way: five samples held, next sample completes it
    write_reg(CFG_SPR, 8'd16);
    for (int i = 0; i < 5; i++) push_item($urandom_range(FULL_SCALE), 0);
    settle();
    write_reg(CFG_SPR, 8'd3);
    push_item($urandom_range(FULL_SCALE), $urandom_range(FULL_SCALE));
    settle();

    // random phases; corners of both registers first
    for (int unsigned ph = 0; sent < RANDOM_ITEMS; ph++) begin
      spr = (ph < 6) ? spr_corner[ph] : SPR_W'($urandom_range(MIN_SAMPLES, MAX_SAMPLES));
      db  = (ph < 3) ? db_corner[ph] : DUTY_W'($urandom_range(0, 40));
      write_reg(CFG_SPR, {3'($urandom), spr});
      write_reg(CFG_DEADBAND, db);
      steady <= (ph == 7);
      chunk = 0;
      while (chunk < PHASE_ITEMS) begin
        n = window_len();
        // now and then a short window that runs into the next one
        if ($urandom_range(9) == 0) n = $urandom_range(1, n);
        push_window(n);
        chunk += n;
      end
      sent += chunk;
      settle();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: servo_trimmed_mean_p_drive.f
+incdir+design
design/stmpd_pkg.sv
design/stmpd_div.sv
design/stmpd_dp.sv
design/stmpd_ctrl.sv
design/servo_trimmed_mean_p_drive.sv
sim/tb.sv
